FILE: rtl/core/lzss_pkg.sv
`default_nettype none
package lzss_pkg;

  // decoder phase codes
  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_ITEM   = 2'd1;
  localparam logic [1:0] PH_MATCH2 = 2'd2;

  localparam int unsigned MATCH_BIAS = 18;
  localparam int unsigned MIN_LEN    = 3;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned FLAG_ITEMS = 8;

endpackage
`default_nettype wire

FILE: rtl/core/lzss_window_decompressor_unit.sv
`default_nettype none
// a literal reaches the output register in the cycle after it is taken; a match's first
// source byte goes into the ram read register as its second byte is taken, then to the
// output register; input is taken back to back, a literal only if the output is free;
// a match gives len bytes (3 to 18), one output byte per cycle out of the history ram
// read port while not stalled, input held off; synchronous reset clears phase, counters
// and handshake state; history ram contents stay; sources before the block read as zero
module lzss_window_decompressor_unit #(
  parameter int unsigned WINDOW_SIZE = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       block_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last
);
  import lzss_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned PW = AW + 1;

  logic [7:0] mem [WINDOW_SIZE];

  logic [1:0]       phase, phase_next;
  logic [7:0]       flag_bits, flag_bits_next;
  logic [3:0]       flags_left, flags_left_next;
  logic [7:0]       offset_low, offset_low_next;
  logic [AW-1:0]    write_pos, write_pos_next;
  logic [PW-1:0]    produced, produced_next;
  logic             copying, copying_next;
  logic [AW-1:0]    src_cur, src_cur_next;
  logic [PW-1:0]    src_dist, src_dist_next;
  logic [LEN_W-1:0] len_left, len_left_next;

  logic [7:0]    rd_q;
  logic [7:0]    wr_last;
  logic          wr_hit;
  logic          mem_we;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;

  // state as seen after an optional block clear
  logic [1:0]    ph_e;
  logic [7:0]    fb_e;
  logic [3:0]    fl_e;
  logic [AW-1:0] wp_e;
  logic [PW-1:0] pc_e;

  logic          accept, out_free, is_lit, adv;
  logic [AW-1:0] src_calc, dist_raw;
  logic [7:0]    copy_val;
  logic [3:0]    fl_dec;
  logic          load_out;
  logic [7:0]    load_byte;
  logic          load_last;

  assign ph_e = block_start ? PH_FLAG : phase;
  assign fb_e = block_start ? 8'd0 : flag_bits;
  assign fl_e = block_start ? 4'd0 : flags_left;
  assign wp_e = block_start ? '0 : write_pos;
  assign pc_e = block_start ? '0 : produced;

  assign out_free = !out_valid || !out_stall;
  assign is_lit   = (ph_e == PH_ITEM) && fb_e[0];
  assign in_stall = copying || (is_lit && !out_free);
  assign accept   = in_valid && !in_stall;
  assign adv      = copying && out_free;

  assign src_calc = AW'({in_byte[7:4], offset_low} + 12'(MATCH_BIAS));
  assign dist_raw = write_pos - src_calc;
  assign fl_dec   = (fl_e != 4'd0) ? fl_e - 4'd1 : 4'd0;

  // a byte written at the edge of its own read comes from the write register
  assign copy_val = (src_dist > produced) ? 8'd0 : (wr_hit ? wr_last : rd_q);

  always_comb begin
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    offset_low_next = offset_low;
    write_pos_next  = write_pos;
    produced_next   = produced;
    copying_next    = copying;
    src_cur_next    = src_cur;
    src_dist_next   = src_dist;
    len_left_next   = len_left;
    mem_we          = 1'b0;
    wr_data         = in_byte;
    load_out        = 1'b0;
    load_byte       = in_byte;
    load_last       = 1'b1;
    rd_addr         = src_calc;

    if (copying) begin
      rd_addr = adv ? src_cur + 1'b1 : src_cur;
      if (adv) begin
        mem_we         = 1'b1;
        wr_data        = copy_val;
        load_out       = 1'b1;
        load_byte      = copy_val;
        load_last      = (len_left == LEN_W'(1));
        write_pos_next = write_pos + 1'b1;
        produced_next  = (produced < PW'(WINDOW_SIZE)) ? produced + 1'b1 : produced;
        src_cur_next   = src_cur + 1'b1;
        len_left_next  = len_left - 1'b1;
        copying_next   = (len_left != LEN_W'(1));
      end
    end else if (accept) begin
      phase_next      = ph_e;
      flag_bits_next  = fb_e;
      flags_left_next = fl_e;
      write_pos_next  = wp_e;
      produced_next   = pc_e;
      if (block_start) begin
        offset_low_next = 8'd0;
      end
      case (ph_e)
        PH_ITEM: begin
          if (fb_e[0]) begin
            mem_we          = 1'b1;
            load_out        = 1'b1;
            write_pos_next  = wp_e + 1'b1;
            produced_next   = (pc_e < PW'(WINDOW_SIZE)) ? pc_e + 1'b1 : pc_e;
            flag_bits_next  = fb_e >> 1;
            flags_left_next = fl_dec;
            phase_next      = (fl_dec == 4'd0) ? PH_FLAG : PH_ITEM;
          end else begin
            offset_low_next = in_byte;
            phase_next      = PH_MATCH2;
          end
        end
        PH_MATCH2: begin
          // read of the first source byte is issued at this edge
          copying_next    = 1'b1;
          src_cur_next    = src_calc;
          src_dist_next   = (dist_raw == '0) ? PW'(WINDOW_SIZE) : {1'b0, dist_raw};
          len_left_next   = LEN_W'(MIN_LEN) + LEN_W'(in_byte[3:0]);
          flag_bits_next  = fb_e >> 1;
          flags_left_next = fl_dec;
          phase_next      = (fl_dec == 4'd0) ? PH_FLAG : PH_ITEM;
        end
        default: begin
          flag_bits_next  = in_byte;
          flags_left_next = 4'(FLAG_ITEMS);
          phase_next      = PH_ITEM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_pos_next - 1'b1] <= wr_data;
    end
    rd_q    <= mem[rd_addr];
    wr_last <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_bits  <= 8'd0;
      flags_left <= 4'd0;
      offset_low <= 8'd0;
      write_pos  <= '0;
      produced   <= '0;
      copying    <= 1'b0;
      len_left   <= '0;
      wr_hit     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
      offset_low <= offset_low_next;
      write_pos  <= write_pos_next;
      produced   <= produced_next;
      copying    <= copying_next;
      len_left   <= len_left_next;
      wr_hit     <= mem_we && ((write_pos_next - 1'b1) == rd_addr);
      if (out_free) begin
        out_valid <= load_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_cur  <= src_cur_next;
    src_dist <= src_dist_next;
    if (out_free && load_out) begin
      out_byte <= load_byte;
      run_last <= load_last;
    end
  end

`ifndef SYNTHESIS
  a_copy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    copying |-> in_stall)
    else $error("input taken during match copy");

  a_copy_len_live: assert property (@(posedge clk) disable iff (rst)
    copying |-> (len_left != '0))
    else $error("match copy running with no bytes left");

  a_produced_sat: assert property (@(posedge clk) disable iff (rst)
    produced <= PW'(WINDOW_SIZE))
    else $error("produced count beyond window");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_hit |-> $past(mem_we))
    else $error("forward flag without a write");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  localparam int unsigned WINDOW          = 4096;
  localparam int unsigned RANDOM_REQUESTS = 290;
  localparam int unsigned QUIET_TAIL      = 40;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SCRIPT_LEN      = 23;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  // fixed rows carry count copies of value, the rest go through the decoder model
  typedef struct packed {
    logic [7:0] code;
    logic       start;
    logic       fixed;
    logic [4:0] count;
    logic [7:0] value;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{8'h55, 1'b1, 1'b1, 5'd0,  8'h00},  // flag: literal and match alternate
    '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hFF, 1'b0, 1'b1, 5'd18, 8'h00},  // longest match, source before block start
    '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF},
    '{8'hEE, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hF0, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'hA5, 1'b0, 1'b1, 5'd1,  8'hA5},
    '{8'h06, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h00, 1'b0, 1'b1, 5'd3,  8'h00},  // source equals write position: full window back
    '{8'h3C, 1'b0, 1'b1, 5'd1,  8'h3C},
    '{8'h09, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h0F, 1'b0, 1'b0, 5'd0,  8'h00},  // copy overlapping its own output
    '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h12, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hFD, 1'b1, 1'b1, 5'd0,  8'h00},  // new block drops the half-read match
    '{8'h80, 1'b0, 1'b1, 5'd1,  8'h80},
    '{8'hEE, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'hE5, 1'b0, 1'b0, 5'd0,  8'h00},
    '{8'h01, 1'b0, 1'b1, 5'd1,  8'h01},
    '{8'h7E, 1'b1, 1'b1, 5'd0,  8'h00},  // restart inside a flag group
    '{8'h33, 1'b0, 1'b1, 5'd0,  8'h00},
    '{8'h0F, 1'b0, 1'b1, 5'd18, 8'h00}
  };

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       block_start = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  always #1 clk = ~clk;

  lzss_window_decompressor_unit #(
    .WINDOW_SIZE(WINDOW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .block_start(block_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .run_last(run_last)
  );

  // decoder model state
  logic [7:0]  ring [WINDOW];
  logic [11:0] wr_pos      = '0;
  int unsigned emitted     = 0;
  logic [7:0]  flag_reg    = '0;
  logic [3:0]  flags_rem   = '0;
  logic [1:0]  dec_phase   = PH_FLAG;
  logic [7:0]  off_lo      = '0;
  logic [3:0]  match_hi    = '0;

  decoded_t fresh [$];
  decoded_t pending [$];
  decoded_t want;

  int unsigned errors        = 0;
  int unsigned requests_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned match_count   = 0;
  int unsigned block_count   = 0;
  int unsigned cycles        = 0;
  int unsigned stall_left    = 0;
  bit          gap_enable    = 1'b1;
  bit          stall_enable  = 1'b1;

  function automatic void clear_block();
    wr_pos    = '0;
    emitted   = 0;
    flag_reg  = '0;
    flags_rem = '0;
    dec_phase = PH_FLAG;
    off_lo    = '0;
  endfunction

  function automatic void emit(logic [7:0] v, logic last);
    ring[wr_pos] = v;
    fresh.push_back('{v, last});
    wr_pos = wr_pos + 12'd1;
    if (emitted < WINDOW) emitted++;
  endfunction

  function automatic void item_done();
    flag_reg = flag_reg >> 1;
    if (flags_rem != 0) flags_rem = flags_rem - 4'd1;
    dec_phase = (flags_rem == 0) ? PH_FLAG : PH_ITEM;
  endfunction

  // advance the decoder by one compressed byte, leaving its output in fresh
  function automatic void decode_request(logic [7:0] b, logic s);
    logic [11:0] src;
    logic [11:0] back;
    int unsigned distance;
    int unsigned len;
    fresh.delete();
    if (s) clear_block();
    case (dec_phase)
      PH_ITEM: begin
        if (flag_reg[0]) begin
          emit(b, 1'b1);
          item_done();
        end else begin
          off_lo    = b;
          dec_phase = PH_MATCH2;
        end
      end
      PH_MATCH2: begin
        src      = {b[7:4], off_lo} + 12'(MATCH_BIAS);
        len      = MIN_LEN + b[3:0];
        back     = wr_pos - src;
        distance = (back == 0) ? WINDOW : back;
        match_count++;
        for (int i = 0; i < len; i++) begin
          emit((distance > emitted) ? 8'h00 : ring[src], i + 1 == len);
          src = src + 12'd1;
        end
        item_done();
      end
      default: begin
        flag_reg  = b;
        flags_rem = 4'(FLAG_ITEMS);
        dec_phase = PH_ITEM;
      end
    endcase
  endfunction

  task automatic send_request(logic [7:0] b, logic s, logic fixed, int unsigned count,
                              logic [7:0] value);
    if (gap_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    block_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_request(b, s);
    if (fixed) begin
      for (int i = 0; i < count; i++) pending.push_back('{value, i + 1 == count});
    end else begin
      foreach (fresh[i]) pending.push_back(fresh[i]);
    end
    requests_sent++;
    if (s) block_count++;
    @(negedge clk);
  endtask

  // mostly well-formed streams that follow the decoder's phase, some noise and restarts
  task automatic next_random(output logic [7:0] b, output logic s);
    logic [1:0]  ph;
    logic [11:0] src;
    logic [11:0] off;
    int unsigned span;
    s  = ($urandom_range(0, 99) < 2);
    ph = s ? PH_FLAG : dec_phase;
    b  = 8'($urandom);
    case (ph)
      PH_ITEM: begin
        if (!flag_reg[0]) begin
          if (emitted != 0 && $urandom_range(0, 99) < 85) begin
            span = ($urandom_range(0, 1) == 0 && emitted > 32) ? 32 : emitted;
            src  = wr_pos - 12'($urandom_range(1, span));
            off  = src - 12'(MATCH_BIAS);
          end else begin
            off = 12'($urandom);
          end
          b        = off[7:0];
          match_hi = off[11:8];
        end
      end
      PH_MATCH2: begin
        b = {match_hi, ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom)};
      end
      default: begin
        if ($urandom_range(0, 9) == 0) s = 1'b1;
        case ($urandom_range(0, 5))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: ;
        endcase
      end
    endcase
    if ($urandom_range(0, 99) < 6) b = 8'($urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0 && stall_enable) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_enable && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected output byte %02h run_last %0b", $time, out_byte, run_last);
        errors++;
      end else begin
        want = pending.pop_front();
        bytes_checked++;
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          errors++;
        end
        if (run_last !== want.last) begin
          $display("%0t: run_last expected %0b actual %0b", $time, want.last, run_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycles, pending.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] rnd_byte;
    logic       rnd_start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_request(SCRIPT[i].code, SCRIPT[i].start, SCRIPT[i].fixed, SCRIPT[i].count,
                   SCRIPT[i].value);
    end
    drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
      end else if (n % 30 == 0) begin
        gap_enable   = ($urandom_range(0, 2) != 0);
        stall_enable = ($urandom_range(0, 2) != 0);
      end
      if (n == RANDOM_REQUESTS / 2) drain();
      next_random(rnd_byte, rnd_start);
      send_request(rnd_byte, rnd_start, 1'b0, 0, 8'h00);
    end
    drain();

    $display("compressed bytes sent %0d over %0d block starts, %0d matches decoded",
             requests_sent, block_count, match_count);
    $display("decoded bytes compared %0d, mismatches %0d", bytes_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
